FILE: hw/rtl/go_to_goal_p_controller_macros.svh
// Assertion macros shared by the controller RTL.
`ifndef GO_TO_GOAL_P_CONTROLLER_MACROS_SVH
`define GO_TO_GOAL_P_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define GTG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtg assertion failed");

// Next-cycle implication, disabled in reset.
`define GTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtg assertion failed");

`endif

FILE: hw/rtl/gtg_pkg.sv
package gtg_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CORDIC_STAGES = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  localparam int POS_W  = 24;
  localparam int HEAD_W = 15;
  localparam int VEC_W  = 36;
  localparam int ANG_W  = 24;
  localparam int GAIN_W = 12;
  localparam int TOL_W  = 24;
  localparam int DIST_W = 26;
  localparam int LIN_W  = 28;
  localparam int AV_W   = 20;

  localparam logic signed [ANG_W-1:0] PI_Q20       = 24'sd3294199;
  localparam logic [23:0]             INV_GAIN_Q24 = 24'd10188014;

  localparam logic signed [ANG_W-1:0] ATAN_Q20 [ATAN_ENTRIES] = '{
    24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
    24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
    24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
    24'sd256,    24'sd128,    24'sd64,     24'sd32,
    24'sd16,     24'sd8,      24'sd4,      24'sd2,
    24'sd1,      24'sd0,      24'sd0,      24'sd0
  };

  localparam logic [1:0] CFG_LINEAR_GAIN    = 2'd0;
  localparam logic [1:0] CFG_ANGULAR_GAIN   = 2'd1;
  localparam logic [1:0] CFG_STOP_TOLERANCE = 2'd2;

  typedef struct packed {
    logic signed [VEC_W-1:0]  x;
    logic signed [VEC_W-1:0]  y;
    logic signed [ANG_W-1:0]  z;
    logic signed [HEAD_W-1:0] heading;
  } gtg_vec_t;

  typedef struct packed {
    logic [GAIN_W-1:0] linear_gain;
    logic [GAIN_W-1:0] angular_gain;
    logic [TOL_W-1:0]  stop_tolerance;
  } gtg_cfg_t;

endpackage

FILE: hw/rtl/gtg_err.sv
`include "go_to_goal_p_controller_macros.svh"

module gtg_err (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [gtg_pkg::POS_W-1:0]  cur_x,
  input  logic signed [gtg_pkg::POS_W-1:0]  cur_y,
  input  logic signed [gtg_pkg::HEAD_W-1:0] cur_heading,
  input  logic signed [gtg_pkg::POS_W-1:0]  goal_x,
  input  logic signed [gtg_pkg::POS_W-1:0]  goal_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gtg_pkg::gtg_vec_t                 out_vec
);

  logic signed [gtg_pkg::POS_W:0]   ex;
  logic signed [gtg_pkg::POS_W:0]   ey;
  logic signed [gtg_pkg::VEC_W-1:0] xs;
  logic signed [gtg_pkg::VEC_W-1:0] ys;
  gtg_pkg::gtg_vec_t                vec_nxt;
  gtg_pkg::gtg_vec_t                vec_r;
  logic                             v_r;
  logic                             v_nxt;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    ex = {goal_x[gtg_pkg::POS_W-1], goal_x} - {cur_x[gtg_pkg::POS_W-1], cur_x};
    ey = {goal_y[gtg_pkg::POS_W-1], goal_y} - {cur_y[gtg_pkg::POS_W-1], cur_y};
    xs = {{(gtg_pkg::VEC_W-gtg_pkg::POS_W-9){ex[gtg_pkg::POS_W]}}, ex, 8'd0};
    ys = {{(gtg_pkg::VEC_W-gtg_pkg::POS_W-9){ey[gtg_pkg::POS_W]}}, ey, 8'd0};
    vec_nxt.heading = cur_heading;
    if (ex[gtg_pkg::POS_W]) begin
      // left half-plane: pre-rotate by pi
      vec_nxt.x = -xs;
      vec_nxt.y = -ys;
      vec_nxt.z = ey[gtg_pkg::POS_W] ? -gtg_pkg::PI_Q20 : gtg_pkg::PI_Q20;
    end else begin
      vec_nxt.x = xs;
      vec_nxt.y = ys;
      vec_nxt.z = '0;
    end
    v_nxt = in_ready ? in_valid : v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_vec   = vec_r;

  `GTG_ASSERT_NEXT(a_take_fills_stage, clk, rst_n, in_valid && in_ready, v_r)

endmodule

FILE: hw/rtl/gtg_cordic.sv
`include "go_to_goal_p_controller_macros.svh"

module gtg_cordic (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gtg_pkg::gtg_vec_t in_vec,
  output logic              out_valid,
  input  logic              out_ready,
  output gtg_pkg::gtg_vec_t out_vec
);

  localparam int N = gtg_pkg::CORDIC_STAGES;

  gtg_pkg::gtg_vec_t vec_r [N];
  logic [N-1:0]      v_r;
  logic [N:0]        rdy;

  assign rdy[N] = out_ready;

  for (genvar k = 0; k < N; k++) begin : g_stage
    gtg_pkg::gtg_vec_t                src;
    gtg_pkg::gtg_vec_t                vec_nxt;
    logic                             src_v;
    logic                             v_nxt;
    logic signed [gtg_pkg::VEC_W-1:0] xs;
    logic signed [gtg_pkg::VEC_W-1:0] ys;

    if (k == 0) begin : g_first
      assign src   = in_vec;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src   = vec_r[k-1];
      assign src_v = v_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_comb begin
      xs = $signed(src.x) >>> k;
      ys = $signed(src.y) >>> k;
      vec_nxt.heading = src.heading;
      if (!src.y[gtg_pkg::VEC_W-1]) begin
        vec_nxt.x = src.x + ys;
        vec_nxt.y = src.y - xs;
        vec_nxt.z = src.z + gtg_pkg::ATAN_Q20[k];
      end else begin
        vec_nxt.x = src.x - ys;
        vec_nxt.y = src.y + xs;
        vec_nxt.z = src.z - gtg_pkg::ATAN_Q20[k];
      end
      v_nxt = rdy[k] ? src_v : v_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        vec_r[k] <= vec_nxt;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_vec   = vec_r[N-1];

  `GTG_ASSERT_NOW(a_x_nonneg, clk, rst_n, v_r[N-1], !vec_r[N-1].x[gtg_pkg::VEC_W-1])

endmodule

FILE: hw/rtl/gtg_scale.sv
`include "go_to_goal_p_controller_macros.svh"

module gtg_scale (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gtg_pkg::gtg_cfg_t               cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gtg_pkg::gtg_vec_t               in_vec,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gtg_pkg::LIN_W-1:0]       linear_velocity,
  output logic signed [gtg_pkg::AV_W-1:0] angular_velocity,
  output logic                            goal_reached
);

  // stage A: split length multiply, heading error
  logic [40:0]        pp_lo_r, pp_hi_r, pp_lo_nxt, pp_hi_nxt;
  logic signed [16:0] err_a_r, err_a_nxt;
  logic signed [23:0] zr;
  logic signed [15:0] ang12;
  // stage B: length
  logic [58:0]                     dsum;
  logic [gtg_pkg::DIST_W-1:0]      dist_r, dist_nxt;
  logic signed [16:0]              err_b_r;
  // stage C: gain products, goal-reached compare
  logic [37:0]        lin_p_r, lin_p_nxt;
  logic signed [29:0] ang_p_r, ang_p_nxt;
  logic               reach_r, reach_nxt;
  // output register
  logic [37:0]                     lin_sum;
  logic [29:0]                     ang_sum;
  logic [gtg_pkg::LIN_W-1:0]       lin_r, lin_nxt;
  logic signed [gtg_pkg::AV_W-1:0] av_r, av_nxt;
  logic                            gr_r, gr_nxt;

  logic [3:0] v_r;
  logic [3:0] v_nxt;
  logic [4:0] rdy;

  assign rdy[4] = out_ready;
  assign rdy[3] = !v_r[3] || rdy[4];
  assign rdy[2] = !v_r[2] || rdy[3];
  assign rdy[1] = !v_r[1] || rdy[2];
  assign rdy[0] = !v_r[0] || rdy[1];

  always_comb begin
    pp_lo_nxt = 41'(in_vec.x[16:0]  * gtg_pkg::INV_GAIN_Q24);
    pp_hi_nxt = 41'(in_vec.x[33:17] * gtg_pkg::INV_GAIN_Q24);
    zr        = in_vec.z + 24'sd128;
    ang12     = zr[23:8];
    err_a_nxt = {ang12[15], ang12} - {{2{in_vec.heading[14]}}, in_vec.heading};

    dsum     = {1'b0, pp_hi_r, 17'd0} + {18'd0, pp_lo_r} + 59'(64'h8000_0000);
    dist_nxt = dsum[57:32];

    reach_nxt = !(dist_r > {2'b00, cfg.stop_tolerance});
    lin_p_nxt = 38'(dist_r * cfg.linear_gain);
    ang_p_nxt = 30'(err_b_r * $signed({1'b0, cfg.angular_gain}));

    lin_sum = lin_p_r + 38'd128;
    ang_sum = ang_p_r + 30'sd128;
    if (reach_r) begin
      lin_nxt = '0;
      av_nxt  = '0;
      gr_nxt  = 1'b1;
    end else begin
      lin_nxt = (lin_sum[37:36] != 2'b00) ? {gtg_pkg::LIN_W{1'b1}} : lin_sum[35:8];
      av_nxt  = ang_sum[27:8];
      gr_nxt  = 1'b0;
    end

    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    v_nxt[1] = rdy[1] ? v_r[0]   : v_r[1];
    v_nxt[2] = rdy[2] ? v_r[1]   : v_r[2];
    v_nxt[3] = rdy[3] ? v_r[2]   : v_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pp_lo_r <= pp_lo_nxt;
      pp_hi_r <= pp_hi_nxt;
      err_a_r <= err_a_nxt;
    end
    if (rdy[1]) begin
      dist_r  <= dist_nxt;
      err_b_r <= err_a_r;
    end
    if (rdy[2]) begin
      lin_p_r <= lin_p_nxt;
      ang_p_r <= ang_p_nxt;
      reach_r <= reach_nxt;
    end
    if (rdy[3]) begin
      lin_r <= lin_nxt;
      av_r  <= av_nxt;
      gr_r  <= gr_nxt;
    end
  end

  assign in_ready         = rdy[0];
  assign out_valid        = v_r[3];
  assign linear_velocity  = lin_r;
  assign angular_velocity = av_r;
  assign goal_reached     = gr_r;

  `GTG_ASSERT_NEXT(a_reach_zero, clk, rst_n, v_r[2] && reach_r && rdy[3], lin_r == '0 && av_r == '0)

endmodule

FILE: hw/rtl/go_to_goal_p_controller.sv
// Go-to-goal proportional controller for a unicycle robot.
// Input channel (in_valid / in_stall): one pose item per accepted cycle,
// current x, y, heading and goal x, y. Output channel (out_valid /
// out_stall): linear and angular velocity commands and a reached flag.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 linear
// gain, 1 angular gain, 2 stop tolerance; other indexes are ignored.
// cfg_ready is always high. Write registers only while the pipeline is empty.
// Pipeline: CORDIC_STEPS + 5 register stages (21 at 16 steps): one error stage,
// one CORDIC stage per step, two length-multiply stages, one gain stage and the
// output register. Throughput is one item per cycle while out_stall is low.
// Stall: each stage holds while the next one is full and stalled, so bubbles
// close up and in_stall rises only when every stage holds an item.
// Reset: clears all valid bits and loads gains 77 and 768, tolerance 66.
module go_to_goal_p_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [gtg_pkg::POS_W-1:0]  in_cur_x,
  input  logic signed [gtg_pkg::POS_W-1:0]  in_cur_y,
  input  logic signed [gtg_pkg::HEAD_W-1:0] in_cur_heading,
  input  logic signed [gtg_pkg::POS_W-1:0]  in_goal_x,
  input  logic signed [gtg_pkg::POS_W-1:0]  in_goal_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gtg_pkg::LIN_W-1:0]         out_linear_velocity,
  output logic signed [gtg_pkg::AV_W-1:0]   out_angular_velocity,
  output logic                              out_goal_reached,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [gtg_pkg::TOL_W-1:0]         cfg_data
);

  `include "go_to_goal_p_controller_macros.svh"

  gtg_pkg::gtg_cfg_t cfg_r;
  gtg_pkg::gtg_cfg_t cfg_nxt;
  gtg_pkg::gtg_vec_t err_vec;
  gtg_pkg::gtg_vec_t cor_vec;
  logic              in_ready;
  logic              err_valid, err_ready;
  logic              cor_valid, cor_ready;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gtg_pkg::CFG_LINEAR_GAIN:    cfg_nxt.linear_gain    = cfg_data[gtg_pkg::GAIN_W-1:0];
        gtg_pkg::CFG_ANGULAR_GAIN:   cfg_nxt.angular_gain   = cfg_data[gtg_pkg::GAIN_W-1:0];
        gtg_pkg::CFG_STOP_TOLERANCE: cfg_nxt.stop_tolerance = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.linear_gain    <= 12'd77;
      cfg_r.angular_gain   <= 12'd768;
      cfg_r.stop_tolerance <= 24'd66;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gtg_err u_err (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cur_x       (in_cur_x),
    .cur_y       (in_cur_y),
    .cur_heading (in_cur_heading),
    .goal_x      (in_goal_x),
    .goal_y      (in_goal_y),
    .out_valid   (err_valid),
    .out_ready   (err_ready),
    .out_vec     (err_vec)
  );

  gtg_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_vec    (err_vec),
    .out_valid (cor_valid),
    .out_ready (cor_ready),
    .out_vec   (cor_vec)
  );

  gtg_scale u_scale (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (cor_valid),
    .in_ready         (cor_ready),
    .in_vec           (cor_vec),
    .out_valid        (out_valid),
    .out_ready        (!out_stall),
    .linear_velocity  (out_linear_velocity),
    .angular_velocity (out_angular_velocity),
    .goal_reached     (out_goal_reached)
  );

  assign in_stall = !in_ready;

  `GTG_ASSERT_NOW(a_reached_zero_out, clk, rst_n, out_valid && out_goal_reached, out_linear_velocity == '0 && out_angular_velocity == '0)
  `GTG_ASSERT_NOW(a_empty_out_accepts, clk, rst_n, !out_valid, !in_stall)

endmodule
